/* sv/bdes_pkg.sv */
// ----------------------------------------------------------------------------
// bdes_pkg
// Shared widths, reset values and beat types of the button debouncer.
// ----------------------------------------------------------------------------
package bdes_pkg;

    localparam int TICK_W  = 20;
    localparam int EDGE_W  = 16;
    localparam int COUNT_W = 32;

    localparam logic [TICK_W-1:0]  TICK_MAX         = {TICK_W{1'b1}};
    localparam logic [EDGE_W-1:0]  EDGE_MAX         = {EDGE_W{1'b1}};
    localparam logic [COUNT_W-1:0] HELD_MAX         = {COUNT_W{1'b1}};
    localparam logic [TICK_W-1:0]  DEBOUNCE_DEFAULT = TICK_W'(10000);

    typedef struct packed {
        logic valid;
        logic pin_low;
    } t_tick;

    typedef struct packed {
        logic               pressed;
        logic [COUNT_W-1:0] press_count;
        logic [EDGE_W-1:0]  edge_count;
        logic [EDGE_W-1:0]  ignored_edges;
        logic [COUNT_W-1:0] held_ticks;
    } t_result;

endpackage

/* sv/bdes_in_stage.sv */
// ----------------------------------------------------------------------------
// bdes_in_stage
// Input register: holds one sample beat until the core takes it.
// ----------------------------------------------------------------------------
module bdes_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_pin_low,
    input  logic           i_take,
    output bdes_pkg::t_tick o_tick
);
    import bdes_pkg::*;

    logic r_valid;
    logic r_pin_low;
    logic n_valid;
    logic w_accept;

    assign o_in_ready = !r_valid || i_take;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pin_low <= i_pin_low;
        end
    end

    assign o_tick.valid   = r_valid;
    assign o_tick.pin_low = r_pin_low;

endmodule

/* sv/bdes_core.sv */
// ----------------------------------------------------------------------------
// bdes_core
// Debounce state, edge statistics and the result register.
// ----------------------------------------------------------------------------
module bdes_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bdes_pkg::TICK_W-1:0]   i_cfg_wdata,
    input  bdes_pkg::t_tick               i_tick,
    output logic                          o_take,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bdes_pkg::t_result             o_result
);
    import bdes_pkg::*;

    logic [TICK_W-1:0]  r_debounce;
    logic               r_prev;
    logic               r_stable;
    logic [TICK_W-1:0]  r_tse;
    logic [EDGE_W-1:0]  r_edges;
    logic [COUNT_W-1:0] r_tsc;
    logic [COUNT_W-1:0] r_presses;
    logic               r_out_valid;
    t_result            r_result;

    logic               w_edge;
    logic               w_change;
    logic [TICK_W-1:0]  n_tse;
    logic [EDGE_W-1:0]  n_edges;
    logic [COUNT_W-1:0] n_tsc;
    logic [COUNT_W-1:0] n_presses;
    logic               n_out_valid;
    t_result            n_result;

    assign o_take = i_tick.valid && (!r_out_valid || i_out_ready);

    always_comb begin
        w_edge = i_tick.pin_low != r_prev;
        if (w_edge) begin
            n_edges = (r_edges != EDGE_MAX) ? r_edges + EDGE_W'(1) : r_edges;
            n_tse   = '0;
        end else begin
            n_edges = r_edges;
            n_tse   = (r_tse != TICK_MAX) ? r_tse + TICK_W'(1) : r_tse;
        end
        n_tsc     = (r_tsc != HELD_MAX) ? r_tsc + COUNT_W'(1) : r_tsc;
        w_change  = (i_tick.pin_low != r_stable) && (n_tse >= r_debounce);
        n_presses = r_presses + COUNT_W'(i_tick.pin_low);

        n_result.pressed       = i_tick.pin_low;
        n_result.press_count   = n_presses;
        n_result.edge_count    = n_edges;
        n_result.ignored_edges = (n_edges != '0) ? n_edges - EDGE_W'(1) : '0;
        n_result.held_ticks    = n_tsc;

        if (o_take) begin
            n_out_valid = w_change;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_DEFAULT;
            r_prev      <= 1'b0;
            r_stable    <= 1'b0;
            r_tse       <= TICK_MAX;
            r_edges     <= '0;
            r_tsc       <= '0;
            r_presses   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
            if (o_take) begin
                r_prev <= i_tick.pin_low;
                r_tse  <= n_tse;
                if (w_change) begin
                    r_stable  <= i_tick.pin_low;
                    r_presses <= n_presses;
                    r_edges   <= '0;
                    r_tsc     <= '0;
                end else begin
                    r_edges <= n_edges;
                    r_tsc   <= n_tsc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_change) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

/* sv/button_debounce_edge_stats.sv */
// ----------------------------------------------------------------------------
// button_debounce_edge_stats
// Quiet-time button debouncer reporting press/release beats with edge stats.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_pin_low
//   out     | output    | o_out_valid / i_out_ready  | o_pressed .. o_held_ticks
//   cfg     | input     | i_cfg_we, no wait          | i_cfg_wdata (debounce)
//
// One sample beat per clock while the result register is not stalled; a
// beat passes the input register, then the compare and counter logic, into
// the result register.
// Reset (synchronous, active low) clears the state to released with a
// saturated quiet counter and the debounce time to 10000 ticks.
// A stalled result register holds the core; the input register then takes
// at most one more beat before o_in_ready drops.
// ----------------------------------------------------------------------------
module button_debounce_edge_stats (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdes_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_pin_low,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_pressed,
    output logic [bdes_pkg::COUNT_W-1:0]   o_press_count,
    output logic [bdes_pkg::EDGE_W-1:0]    o_edge_count,
    output logic [bdes_pkg::EDGE_W-1:0]    o_ignored_edges,
    output logic [bdes_pkg::COUNT_W-1:0]   o_held_ticks
);
    import bdes_pkg::*;

    t_tick   w_tick;
    t_result w_result;
    logic    w_take;

    bdes_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pin_low  (i_pin_low),
        .i_take     (w_take),
        .o_tick     (w_tick)
    );

    bdes_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tick      (w_tick),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_pressed       = w_result.pressed;
    assign o_press_count   = w_result.press_count;
    assign o_edge_count    = w_result.edge_count;
    assign o_ignored_edges = w_result.ignored_edges;
    assign o_held_ticks    = w_result.held_ticks;

endmodule

/* sv/bdes_checker.sv */
// ----------------------------------------------------------------------------
// bdes_checker
// Port-level checks of the button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module bdes_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [bdes_pkg::TICK_W-1:0]    i_cfg_wdata,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_pin_low,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_pressed,
    input logic [bdes_pkg::COUNT_W-1:0]   o_press_count,
    input logic [bdes_pkg::EDGE_W-1:0]    o_edge_count,
    input logic [bdes_pkg::EDGE_W-1:0]    o_ignored_edges,
    input logic [bdes_pkg::COUNT_W-1:0]   o_held_ticks
);
    import bdes_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_pressed) && $stable(o_press_count) && $stable(o_edge_count)
            && $stable(o_held_ticks))
        else $error("result payload changed while stalled");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a stalled result");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_edge_count == '0 && o_ignored_edges == '0) ||
            (o_edge_count != '0 && o_ignored_edges == o_edge_count - EDGE_W'(1)))
        else $error("ignored edge count inconsistent");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_held_ticks != '0)
        else $error("result with zero held ticks");

endmodule

bind button_debounce_edge_stats bdes_checker u_bdes_checker (.*);
